// File: rtl/rvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared constants, codes and types for the RV32I subset step core.
// ----------------------------------------------------------------------------
package rvs_pkg;

	// default memory size in bytes
	localparam int MEM_BYTES_DEF = 4096;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int PC_W   = 13;
	localparam int ST_W   = 3;
	localparam int IDX_W  = 10;
	localparam int RA_W   = 5;
	localparam int NREGS  = 32;

	// result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// input word operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// instruction opcodes and funct3 codes
	localparam logic [6:0] OPC_ADDI  = 7'h13;
	localparam logic [6:0] OPC_ADD   = 7'h33;
	localparam logic [6:0] OPC_LOAD  = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [2:0] F3_ADD    = 3'd0;
	localparam logic [2:0] F3_WORD   = 3'd2;

	// stack pointer register
	localparam logic [RA_W-1:0] REG_SP = 5'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
	localparam logic [ST_W-1:0] ST_HALT      = 3'd1;
	localparam logic [ST_W-1:0] ST_LOAD_ERR  = 3'd2;
	localparam logic [ST_W-1:0] ST_STORE_ERR = 3'd3;
	localparam logic [ST_W-1:0] ST_NOOP      = 3'd4;

	// one result word
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [PC_W-1:0]   pc_after;
		logic              reg_written;
		logic [RA_W-1:0]   reg_index;
		logic [DATA_W-1:0] reg_value;
	} res_t;

	// data memory access command
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_cmd_t;

endpackage

// File: rtl/rvs_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_dmem
// Byte-addressed little-endian data memory built from four byte-wide banks,
// one word access per cycle at any byte alignment once cleared, registered read data.
// Zeroes itself row by row after reset.
// ----------------------------------------------------------------------------
module rvs_dmem #(
	parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF,
	localparam int ROWS = (MEM_BYTES + 3) / 4,
	localparam int RW   = $clog2(ROWS),
	localparam int AW   = RW + 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rvs_pkg::mem_cmd_t           cmd,
	input  logic [AW-1:0]               addr,
	input  logic [rvs_pkg::DATA_W-1:0]  wdata,
	output logic [rvs_pkg::DATA_W-1:0]  rdata,
	output logic                        clr_busy
);

	logic [RW-1:0] row_base;
	logic [1:0]    offs;
	logic [1:0]    offs_q;
	logic [RW-1:0] clr_row_q;
	logic          clr_busy_q;
	logic          bank_we;
	logic          bank_re;
	logic [RW-1:0] lane_row [4];
	logic [7:0]    lane_wd  [4];
	logic [7:0]    lane_q   [4];

	assign row_base = addr[AW-1:2];
	assign offs     = addr[1:0];
	assign clr_busy = clr_busy_q;
	assign bank_we  = clr_busy_q || cmd.wr_en;
	assign bank_re  = cmd.rd_en && !clr_busy_q;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// per-lane row and write byte; lanes below the offset sit on the next row
	always_comb begin
		logic [1:0] wsel;
		wsel = '0;
		for (int j = 0; j < 4; j++) begin
			wsel = 2'(j) - offs;
			if (clr_busy_q) begin
				lane_row[j] = clr_row_q;
				lane_wd[j]  = '0;
			end else begin
				lane_row[j] = row_base + ((2'(j) < offs) ? RW'(1) : RW'(0));
				lane_wd[j]  = wdata[8*wsel +: 8];
			end
		end
	end

	// byte banks
	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [7:0] bank [ROWS];
		always_ff @(posedge clk) begin
			if (bank_we) begin
				bank[lane_row[j]] <= lane_wd[j];
			end
			if (bank_re) begin
				lane_q[j] <= bank[lane_row[j]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bank_re) begin
			offs_q <= offs;
		end
	end

	// rotate lanes back into word order
	always_comb begin
		logic [1:0] rsel;
		rsel = '0;
		for (int k = 0; k < 4; k++) begin
			rsel = offs_q + 2'(k);
			rdata[8*k +: 8] = lane_q[rsel];
		end
	end

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("dmem: read and write requested together");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(cmd.rd_en || cmd.wr_en))
		else $error("dmem: access during clearing sweep");

endmodule

// File: rtl/rvs_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_regfile
// 32 x 32 register file: two registered read ports, one write port.
// Per-entry valid flags stand in for the reset values; the caller
// substitutes the reset value for an entry never written.
// ----------------------------------------------------------------------------
module rvs_regfile (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rvs_pkg::RA_W-1:0]    ra1,
	input  logic [rvs_pkg::RA_W-1:0]    ra2,
	input  logic                        we,
	input  logic [rvs_pkg::RA_W-1:0]    wa,
	input  logic [rvs_pkg::DATA_W-1:0]  wd,
	output logic [rvs_pkg::DATA_W-1:0]  rd1,
	output logic [rvs_pkg::DATA_W-1:0]  rd2,
	output logic [1:0]                  rd_vld
);

	logic [rvs_pkg::DATA_W-1:0] rf_mem [rvs_pkg::NREGS];
	logic [rvs_pkg::NREGS-1:0]  vld_q;
	logic [rvs_pkg::DATA_W-1:0] q1_q;
	logic [rvs_pkg::DATA_W-1:0] q2_q;
	logic [1:0]                 rv_q;

	// written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// storage, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			rf_mem[wa] <= wd;
		end
		q1_q <= rf_mem[ra1];
		q2_q <= rf_mem[ra2];
		rv_q <= {vld_q[ra2], vld_q[ra1]};
	end

	assign rd1    = q1_q;
	assign rd2    = q2_q;
	assign rd_vld = rv_q;

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (wa != '0))
		else $error("regfile: write to x0");

endmodule

// File: rtl/rvs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_outq
// Result queue between the core pipeline and the output channel.
// The pipeline pushes without back-pressure; space is reserved upstream.
// ----------------------------------------------------------------------------
module rvs_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rvs_pkg::res_t              din,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rvs_pkg::res_t              dout,
	output logic [rvs_pkg::OQ_AW:0]    cnt
);

	rvs_pkg::res_t              oq_mem [rvs_pkg::OQ_DEPTH];
	logic [rvs_pkg::OQ_AW-1:0]  wp_q;
	logic [rvs_pkg::OQ_AW-1:0]  rp_q;
	logic [rvs_pkg::OQ_AW:0]    cnt_q;
	logic                       pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign dout      = oq_mem[rp_q];
	assign cnt       = cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + rvs_pkg::OQ_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + rvs_pkg::OQ_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (rvs_pkg::OQ_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (rvs_pkg::OQ_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_mem[wp_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < (rvs_pkg::OQ_AW + 1)'(rvs_pkg::OQ_DEPTH) || pop))
		else $error("outq: push into full queue");

endmodule

// File: rtl/rv32i_subset_step_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_step_core_unit
// RV32I subset core (ADDI, ADD, LW, SW) stepped one instruction per input
// word, with program loading through the same channel.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid, in_stall | operation, word_index, word_data
//   out     | out_valid,out_stall| status, pc_after, reg_written, reg_index,
//           |                    | reg_value
//
// Program writes can follow one another every cycle while in_stall is low.
// A step passes through fetch, register read and execute with load/store
// access; the next word is taken only once the step's execute is done, as
// set by the data memory port and the register file read latency.
// Every result passes stages s1, s2 and s3 unstalled and is pushed from s3.
// After reset the data memory is zeroed row by row, with in_stall high
// until every row is clear.
// out_stall never stalls the pipeline; queue space is reserved at accept.
// ----------------------------------------------------------------------------
module rv32i_subset_step_core_unit #(
	parameter int MEM_BYTES = rvs_pkg::MEM_BYTES_DEF,
	localparam int ROWS = (MEM_BYTES + 3) / 4,
	localparam int RW   = $clog2(ROWS),
	localparam int AW   = RW + 2,
	localparam int PCW  = $clog2(MEM_BYTES + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [rvs_pkg::IDX_W-1:0]          word_index,
	input  logic [rvs_pkg::DATA_W-1:0]         word_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rvs_pkg::ST_W-1:0]           status,
	output logic [rvs_pkg::PC_W-1:0]           pc_after,
	output logic                               reg_written,
	output logic [rvs_pkg::RA_W-1:0]           reg_index,
	output logic signed [rvs_pkg::DATA_W-1:0]  reg_value
);

	localparam logic [rvs_pkg::DATA_W-1:0] SP_INIT = rvs_pkg::DATA_W'(MEM_BYTES);

	// handshake and resources
	logic                        in_acc;
	logic                        acc_step;
	logic                        clr_busy;
	logic                        credit_ok;
	logic [rvs_pkg::OQ_AW:0]     oq_cnt;
	logic [rvs_pkg::OQ_AW:0]     in_flight;
	rvs_pkg::res_t               oq_dout;

	// memory port
	rvs_pkg::mem_cmd_t           mcmd;
	logic [AW-1:0]               maddr;
	logic [rvs_pkg::DATA_W-1:0]  mwdata;
	logic [rvs_pkg::DATA_W-1:0]  mrdata;

	// register file
	logic [rvs_pkg::DATA_W-1:0]  rf_q1;
	logic [rvs_pkg::DATA_W-1:0]  rf_q2;
	logic [1:0]                  rf_vld;
	logic                        rf_we;
	logic [rvs_pkg::DATA_W-1:0]  rf_wd;

	// architectural program counter
	logic [PCW-1:0]              pc_q;
	logic                        fetch_ok;
	logic                        wr_ok;

	// pipeline stages
	logic                        vld_s1;
	logic                        step_s1;
	logic                        fok_s1;
	logic [PCW-1:0]              pc_s1;
	logic                        vld_s2;
	logic                        step_s2;
	logic                        fok_s2;
	logic [PCW-1:0]              pc_s2;
	logic [rvs_pkg::DATA_W-1:0]  inst_s2;
	logic                        vld_s3;
	logic                        load_s3;
	rvs_pkg::res_t               res_s3;
	rvs_pkg::res_t               res_fin;

	// execute-stage decode
	logic [6:0]                  ex_opc;
	logic [2:0]                  ex_f3;
	logic [rvs_pkg::RA_W-1:0]    ex_rd;
	logic [rvs_pkg::RA_W-1:0]    ex_rs1;
	logic [rvs_pkg::RA_W-1:0]    ex_rs2;
	logic [rvs_pkg::DATA_W-1:0]  rs1_v;
	logic [rvs_pkg::DATA_W-1:0]  rs2_v;
	logic [rvs_pkg::DATA_W-1:0]  imm_i;
	logic [rvs_pkg::DATA_W-1:0]  imm_s;
	logic [rvs_pkg::DATA_W-1:0]  imm_m;
	logic [rvs_pkg::DATA_W-1:0]  ex_sum;
	logic [rvs_pkg::DATA_W:0]    ex_ea;
	logic                        ea_ok;
	logic                        is_addi;
	logic                        is_add;
	logic                        is_lw;
	logic                        is_sw;
	logic                        ex_halt;
	logic                        ex_ld;
	logic                        ex_st;
	logic                        ex_dest;
	logic                        ex_adv;
	logic [rvs_pkg::ST_W-1:0]    ex_status;
	logic                        ex_busy;

	// accept control: a step blocks the channel until its execute cycle is done
	assign in_flight = (rvs_pkg::OQ_AW + 1)'(vld_s1) + (rvs_pkg::OQ_AW + 1)'(vld_s2)
		+ (rvs_pkg::OQ_AW + 1)'(vld_s3);
	assign credit_ok = (in_flight + oq_cnt) < (rvs_pkg::OQ_AW + 1)'(rvs_pkg::OQ_DEPTH);
	assign in_stall  = clr_busy || (vld_s1 && step_s1) || (vld_s2 && step_s2) || !credit_ok;
	assign in_acc    = in_valid && !in_stall;
	assign acc_step  = in_acc && (operation == rvs_pkg::OP_STEP);
	assign ex_busy   = vld_s2 && step_s2;

	// range checks at accept
	assign fetch_ok = (32'(pc_q) + 32'd3) < 32'(MEM_BYTES);
	assign wr_ok    = ((32'(word_index) << 2) + 32'd3) < 32'(MEM_BYTES);

	// memory port: execute stage has it, otherwise the accepted word
	always_comb begin
		mcmd   = '0;
		maddr  = AW'(pc_q);
		mwdata = word_data;
		if (ex_busy) begin
			mcmd.rd_en = ex_ld;
			mcmd.wr_en = ex_st;
			maddr      = ex_ea[AW-1:0];
			mwdata     = rs2_v;
		end else if (in_acc) begin
			if (operation == rvs_pkg::OP_STEP) begin
				mcmd.rd_en = fetch_ok;
			end else begin
				mcmd.wr_en = wr_ok;
				maddr      = AW'({word_index, 2'b00});
			end
		end
	end

	rvs_dmem #(
		.MEM_BYTES (MEM_BYTES)
	) u_dmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mcmd),
		.addr     (maddr),
		.wdata    (mwdata),
		.rdata    (mrdata),
		.clr_busy (clr_busy)
	);

	// register reads addressed straight from the fetched word
	rvs_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.ra1    (mrdata[19:15]),
		.ra2    (mrdata[24:20]),
		.we     (rf_we),
		.wa     (res_s3.reg_index),
		.wd     (rf_wd),
		.rd1    (rf_q1),
		.rd2    (rf_q2),
		.rd_vld (rf_vld)
	);

	// decode and execute
	assign ex_opc = inst_s2[6:0];
	assign ex_f3  = inst_s2[14:12];
	assign ex_rd  = inst_s2[11:7];
	assign ex_rs1 = inst_s2[19:15];
	assign ex_rs2 = inst_s2[24:20];

	// never-written registers read as their reset value
	assign rs1_v = rf_vld[0] ? rf_q1 : ((ex_rs1 == rvs_pkg::REG_SP) ? SP_INIT : '0);
	assign rs2_v = rf_vld[1] ? rf_q2 : ((ex_rs2 == rvs_pkg::REG_SP) ? SP_INIT : '0);

	assign imm_i = {{20{inst_s2[31]}}, inst_s2[31:20]};
	assign imm_s = {{20{inst_s2[31]}}, inst_s2[31:25], inst_s2[11:7]};

	assign is_addi = (ex_opc == rvs_pkg::OPC_ADDI)  && (ex_f3 == rvs_pkg::F3_ADD);
	assign is_add  = (ex_opc == rvs_pkg::OPC_ADD)   && (ex_f3 == rvs_pkg::F3_ADD);
	assign is_lw   = (ex_opc == rvs_pkg::OPC_LOAD)  && (ex_f3 == rvs_pkg::F3_WORD);
	assign is_sw   = (ex_opc == rvs_pkg::OPC_STORE) && (ex_f3 == rvs_pkg::F3_WORD);

	assign ex_halt = !fok_s2 || (inst_s2 == '0);
	assign ex_sum  = rs1_v + (is_add ? rs2_v : imm_i);

	// effective address, signed and without wraparound
	assign imm_m = is_sw ? imm_s : imm_i;
	assign ex_ea = {rs1_v[31], rs1_v} + {imm_m[31], imm_m};
	assign ea_ok = !ex_ea[rvs_pkg::DATA_W] && (ex_ea[rvs_pkg::DATA_W-1:0] < 32'(MEM_BYTES - 3));

	assign ex_ld = !ex_halt && is_lw && ea_ok;
	assign ex_st = !ex_halt && is_sw && ea_ok;

	always_comb begin
		if (ex_halt) begin
			ex_status = rvs_pkg::ST_HALT;
		end else if (is_addi || is_add) begin
			ex_status = rvs_pkg::ST_DONE;
		end else if (is_lw) begin
			ex_status = ea_ok ? rvs_pkg::ST_DONE : rvs_pkg::ST_LOAD_ERR;
		end else if (is_sw) begin
			ex_status = ea_ok ? rvs_pkg::ST_DONE : rvs_pkg::ST_STORE_ERR;
		end else begin
			ex_status = rvs_pkg::ST_NOOP;
		end
	end

	assign ex_adv  = (ex_status == rvs_pkg::ST_DONE) || (ex_status == rvs_pkg::ST_NOOP);
	assign ex_dest = !ex_halt && (is_addi || is_add || (is_lw && ea_ok)) && (ex_rd != '0);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			pc_q   <= '0;
		end else begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (ex_busy && ex_adv) begin
				pc_q <= pc_s2 + PCW'(4);
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		step_s1 <= (operation == rvs_pkg::OP_STEP);
		fok_s1  <= fetch_ok;
		pc_s1   <= pc_q;
		step_s2 <= step_s1;
		fok_s2  <= fok_s1;
		pc_s2   <= pc_s1;
		inst_s2 <= mrdata;
		if (step_s2) begin
			load_s3              <= ex_dest && is_lw;
			res_s3.status        <= ex_status;
			res_s3.pc_after      <= (rvs_pkg::PC_W)'(ex_adv ? (pc_s2 + PCW'(4)) : pc_s2);
			res_s3.reg_written   <= ex_dest;
			res_s3.reg_index     <= ex_dest ? ex_rd : '0;
			res_s3.reg_value     <= (ex_dest && !is_lw) ? ex_sum : '0;
		end else begin
			load_s3              <= 1'b0;
			res_s3.status        <= rvs_pkg::ST_DONE;
			res_s3.pc_after      <= (rvs_pkg::PC_W)'(pc_s2);
			res_s3.reg_written   <= 1'b0;
			res_s3.reg_index     <= '0;
			res_s3.reg_value     <= '0;
		end
	end

	// final stage: load data arrives, register write-back, queue push
	always_comb begin
		res_fin = res_s3;
		if (load_s3) begin
			res_fin.reg_value = mrdata;
		end
	end

	assign rf_we = vld_s3 && res_s3.reg_written;
	assign rf_wd = res_fin.reg_value;

	rvs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s3),
		.din       (res_fin),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (oq_dout),
		.cnt       (oq_cnt)
	);

	assign status      = oq_dout.status;
	assign pc_after    = oq_dout.pc_after;
	assign reg_written = oq_dout.reg_written;
	assign reg_index   = oq_dout.reg_index;
	assign reg_value   = $signed(oq_dout.reg_value);

	a_step_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		acc_step |=> !in_acc ##1 !in_acc)
		else $error("core: word accepted while a step is before execute");

	a_pc_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != $past(pc_q)) |-> (pc_q == $past(pc_q) + PCW'(4)))
		else $error("core: program counter moved by other than one word");

endmodule

// File: tb/rv32i_subset_step_core_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_step_core_unit_tb
// Loads short programs through the input channel and steps the core, checking
// every result word against a cycle-free model of the core kept here. A short
// directed part covers the extremes and each error path; random program bursts
// follow, and the run ends by stepping the core off the top of memory.
// ----------------------------------------------------------------------------
module rv32i_subset_step_core_unit_tb;
	import rvs_pkg::*;

	localparam int MEM_BYTES = MEM_BYTES_DEF;
	localparam int MEM_WORDS = MEM_BYTES / 4;
	localparam logic [6:0] OPC_UNKNOWN = 7'h7F;

	// one input word
	typedef struct {
		logic        op;
		logic [9:0]  idx;
		logic [31:0] data;
	} core_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic [IDX_W-1:0] word_index = '0;
	logic [DATA_W-1:0] word_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic [PC_W-1:0] pc_after;
	logic reg_written;
	logic [RA_W-1:0] reg_index;
	logic signed [DATA_W-1:0] reg_value;

	// model state of the core
	logic [7:0]  mem_img [MEM_BYTES];
	logic [31:0] core_regs [NREGS];
	logic [PC_W-1:0] core_pc;

	core_word_t pending_words [$];
	res_t expected_results [$];
	core_word_t drive_word;
	int n_pushed = 0;
	int n_accepted = 0;
	int n_errors = 0;
	bit in_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	rv32i_subset_step_core_unit #(.MEM_BYTES(MEM_BYTES)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.word_index (word_index),
		.word_data  (word_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.pc_after   (pc_after),
		.reg_written(reg_written),
		.reg_index  (reg_index),
		.reg_value  (reg_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// little-endian memory access
	function automatic logic [31:0] mem_word(int unsigned a);
		return {mem_img[a + 3], mem_img[a + 2], mem_img[a + 1], mem_img[a]};
	endfunction

	task automatic mem_put(int unsigned a, logic [31:0] v);
		{mem_img[a + 3], mem_img[a + 2], mem_img[a + 1], mem_img[a]} = v;
	endtask

	// instruction encoders
	function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
			logic [4:0] rs1, logic [11:0] imm);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_add(logic [6:0] f7, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2);
		return {f7, rs2, rs1, F3_ADD, rd, OPC_ADD};
	endfunction

	function automatic logic [31:0] enc_sw(logic [4:0] rs2, logic [4:0] rs1, logic [11:0] imm);
		return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
	endfunction

	// executes one word on the model state and returns its result
	task automatic core_exec(input logic op, input logic [9:0] idx, input logic [31:0] data,
			output res_t r);
		logic [31:0] inst;
		logic [31:0] res;
		logic [6:0] opc;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [2:0] f3;
		logic [11:0] imm_s;
		logic dest;
		longint ea;
		r = '0;
		res = '0;
		dest = 1'b0;
		if (op == OP_WRITE) begin
			if (int'(idx) * 4 + 3 < MEM_BYTES)
				mem_put(int'(idx) * 4, data);
		end else if (int'(core_pc) + 3 >= MEM_BYTES) begin
			r.status = ST_HALT;
		end else begin
			inst = mem_word(core_pc);
			if (inst == '0) begin
				r.status = ST_HALT;
			end else begin
				opc = inst[6:0];
				rd = inst[11:7];
				f3 = inst[14:12];
				rs1 = inst[19:15];
				rs2 = inst[24:20];
				imm_s = {inst[31:25], inst[11:7]};
				if (opc == OPC_ADDI && f3 == F3_ADD) begin
					res = core_regs[rs1] + {{20{inst[31]}}, inst[31:20]};
					dest = 1'b1;
				end else if (opc == OPC_ADD && f3 == F3_ADD) begin
					res = core_regs[rs1] + core_regs[rs2];
					dest = 1'b1;
				end else if (opc == OPC_LOAD && f3 == F3_WORD) begin
					// effective address without wraparound
					ea = longint'($signed(core_regs[rs1])) + longint'($signed(inst[31:20]));
					if (ea >= 0 && ea + 3 < MEM_BYTES) begin
						res = mem_word(int'(ea));
						dest = 1'b1;
					end else begin
						r.status = ST_LOAD_ERR;
					end
				end else if (opc == OPC_STORE && f3 == F3_WORD) begin
					ea = longint'($signed(core_regs[rs1])) + longint'($signed(imm_s));
					if (ea >= 0 && ea + 3 < MEM_BYTES)
						mem_put(int'(ea), core_regs[rs2]);
					else
						r.status = ST_STORE_ERR;
				end else begin
					r.status = ST_NOOP;
				end
				// x0 is never written, so it always reads zero
				if (dest && rd != '0) begin
					core_regs[rd] = res;
					r.reg_written = 1'b1;
					r.reg_index = rd;
					r.reg_value = res;
				end
				if (r.status == ST_DONE || r.status == ST_NOOP)
					core_pc = core_pc + 13'd4;
			end
		end
		r.pc_after = core_pc;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		n_errors++;
	endtask

	// data values biased towards the extremes
	function automatic logic [31:0] rand_data();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// random instruction, mostly well formed; load/store bases taken from the
	// current model registers so that most addresses land in memory
	function automatic logic [31:0] rand_insn();
		int kind;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [11:0] imm;
		logic [6:0] opc;
		logic [2:0] f3;
		logic [31:0] w;
		longint v;
		longint lo;
		longint hi;
		kind = $urandom_range(0, 99);
		rd = 5'($urandom);
		rs1 = 5'($urandom);
		rs2 = 5'($urandom);
		imm = 12'($urandom);
		if (kind < 25) begin
			if ($urandom_range(0, 1))
				rs1 = '0;
			w = enc_i(OPC_ADDI, rd, F3_ADD, rs1, imm);
		end else if (kind < 45) begin
			w = enc_add(7'($urandom), rd, rs1, rs2);
		end else if (kind < 85) begin
			if ($urandom_range(0, 6) != 0) begin
				v = longint'($signed(core_regs[rs1]));
				if (v < 0 || v > MEM_BYTES - 4 + 2047) begin
					rs1 = '0;
					v = 0;
				end
				lo = (v > 2048) ? -2048 : -v;
				hi = (MEM_BYTES - 4 - v < 2047) ? MEM_BYTES - 4 - v : 2047;
				imm = 12'(lo + longint'($urandom_range(0, int'(hi - lo))));
			end
			w = (kind < 65) ? enc_i(OPC_LOAD, rd, F3_WORD, rs1, imm) : enc_sw(rs2, rs1, imm);
		end else if (kind < 95) begin
			// no-op: a known opcode with a wrong funct3, or an unknown opcode
			w = $urandom;
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: opc = OPC_ADDI;
					1: opc = OPC_ADD;
					2: opc = OPC_LOAD;
					default: opc = OPC_STORE;
				endcase
				f3 = w[14:12];
				if ((opc == OPC_ADDI || opc == OPC_ADD) && f3 == F3_ADD)
					f3 = ~f3;
				if ((opc == OPC_LOAD || opc == OPC_STORE) && f3 == F3_WORD)
					f3 = ~f3;
				w[14:12] = f3;
			end else begin
				opc = 7'($urandom);
				if (opc == OPC_ADDI || opc == OPC_ADD || opc == OPC_LOAD || opc == OPC_STORE)
					opc[6] = ~opc[6];
			end
			w[6:0] = opc;
		end else begin
			w = $urandom;
		end
		return w;
	endfunction

	task automatic push_item(logic op, int idx, logic [31:0] data);
		core_word_t w;
		w.op = op;
		w.idx = idx[9:0];
		w.data = data;
		pending_words.push_back(w);
		n_pushed++;
	endtask

	task automatic push_steps(int n);
		repeat (n)
			push_item(OP_STEP, $urandom_range(0, MEM_WORDS - 1), $urandom);
	endtask

	// every pushed word accepted, so the model state is current
	task automatic wait_accepted();
		do @(negedge clk); while (n_accepted != n_pushed);
	endtask

	task automatic wait_results();
		do @(negedge clk); while (n_accepted != n_pushed || expected_results.size() != 0);
	endtask

	// one program burst written at the program counter, some data, then steps
	task automatic run_burst();
		int base;
		int room;
		int k;
		wait_accepted();
		if ($urandom_range(0, 19) == 0)
			wait_results();
		base = int'(core_pc) / 4;
		room = (int'(core_pc) < MEM_BYTES) ? MEM_WORDS - base : 0;
		k = $urandom_range(1, 8);
		if (k > room)
			k = room;
		for (int i = 0; i < k; i++)
			push_item(OP_WRITE, base + i, rand_insn());
		repeat ($urandom_range(0, 2))
			push_item(OP_WRITE, $urandom_range(0, MEM_WORDS - 1), rand_data());
		push_steps(k + ($urandom_range(0, 3) == 0));
	endtask

	// input driver: new word only once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drive_word = pending_words.pop_front();
					in_valid <= 1'b1;
					operation <= drive_word.op;
					word_index <= drive_word.idx;
					word_data <= drive_word.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result check and prediction of accepted words
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", 32'(status), '0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (pc_after !== want.pc_after)
						report_mismatch("pc_after", 32'(pc_after), 32'(want.pc_after));
					if (reg_written !== want.reg_written)
						report_mismatch("reg_written", 32'(reg_written), 32'(want.reg_written));
					if (reg_index !== want.reg_index)
						report_mismatch("reg_index", 32'(reg_index), 32'(want.reg_index));
					if (reg_value !== want.reg_value)
						report_mismatch("reg_value", reg_value, want.reg_value);
				end
			end
			if (in_valid && !in_stall) begin
				core_exec(operation, word_index, word_data, got);
				expected_results.push_back(got);
				n_accepted++;
				in_taken = 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("rv32i_subset_step_core_unit test failed");
		$finish;
	end

	initial begin
		int start;
		foreach (mem_img[i])
			mem_img[i] = '0;
		foreach (core_regs[i])
			core_regs[i] = '0;
		core_regs[REG_SP] = MEM_BYTES;
		core_pc = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 29;
		recv_idle_pct = 70;

		// directed program: extremes, x0 destination, top-of-memory access,
		// load error repeated, store error, both no-op kinds, unaligned load, halt
		push_item(OP_WRITE, 0, enc_i(OPC_ADDI, 5'd1, F3_ADD, 5'd0, 12'hFFF));
		push_item(OP_WRITE, 1, enc_i(OPC_ADDI, 5'd0, F3_ADD, 5'd1, 12'd5));
		push_item(OP_WRITE, 2, enc_add(7'h7F, 5'd3, 5'd1, REG_SP));
		push_item(OP_WRITE, 3, enc_sw(5'd1, REG_SP, 12'hFFC));
		push_item(OP_WRITE, 4, enc_i(OPC_LOAD, 5'd4, F3_WORD, REG_SP, 12'hFFC));
		push_item(OP_WRITE, 5, enc_i(OPC_LOAD, 5'd5, F3_WORD, REG_SP, 12'hFFD));
		push_steps(7);
		push_item(OP_WRITE, 5, enc_sw(5'd1, 5'd0, 12'hFFF));
		push_steps(1);
		push_item(OP_WRITE, 5, {25'h1FF_FFFF, OPC_UNKNOWN});
		push_steps(1);
		push_item(OP_WRITE, 6, enc_i(OPC_ADDI, 5'd7, ~F3_ADD, 5'd0, 12'h7FF));
		push_steps(1);
		push_item(OP_WRITE, 511, 32'h8000_0001);
		push_item(OP_WRITE, 512, 32'hFFFF_FFFF);
		push_item(OP_WRITE, 7, enc_i(OPC_LOAD, 5'd31, F3_WORD, 5'd0, 12'h7FF));
		push_steps(3);

		// random bursts in three idling phases
		start = n_pushed;
		for (int ph = 0; ph < 3; ph++) begin
			while (n_pushed < start + (ph + 1) * 650)
				run_burst();
			wait_results();
			send_idle_pct = (ph == 0) ? 70 : 0;
			recv_idle_pct = (ph == 0) ? 29 : 0;
		end

		// fill the rest of memory with no-ops and step off the top
		wait_accepted();
		for (int i = int'(core_pc) / 4; i < MEM_WORDS; i++)
			push_item(OP_WRITE, i, {7'($urandom), 18'($urandom), OPC_UNKNOWN});
		push_steps((MEM_BYTES - int'(core_pc)) / 4 + 2);

		wait_results();
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("rv32i_subset_step_core_unit test passed");
		else
			$display("rv32i_subset_step_core_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rvs_pkg.sv
rtl/rvs_dmem.sv
rtl/rvs_regfile.sv
rtl/rvs_outq.sv
rtl/rv32i_subset_step_core_unit.sv
tb/rv32i_subset_step_core_unit_tb.sv
